// ===== design/ptcl_pkg.sv =====
// Shared types and constants for the periodic timer with clock latch.
// No dependencies; used by every module of the block.
package ptcl_pkg;

    // Width of the nanosecond time base and of the latched clocks.
    localparam int TIME_W = 64;
    // Width of a period step in ns: (2^32 - 1) * 1000 stays below 2^42.
    localparam int STEP_W = 42;
    // Microseconds to nanoseconds.
    localparam int US_TO_NS = 1000;
    // Configuration address width and register byte addresses.
    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_REALTIME_START  = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_MONOTONIC_START = 4'h8;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_PERIOD = 2'd2;

    // Clock select codes for reads.
    localparam logic [1:0] SEL_REAL = 2'd0;
    localparam logic [1:0] SEL_MONO = 2'd1;
    localparam logic [1:0] SEL_BOOT = 2'd2;

    // Configuration write event seen by the core.
    typedef struct packed {
        logic              wr_realtime;
        logic              wr_monotonic;
        logic [TIME_W-1:0] value;
    } t_cfg_wr;

    // Status of the remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

// ===== design/ptcl_rem.sv =====
// Bit-serial remainder unit: one restoring step per cycle over a 64-bit dividend.
// Depends on ptcl_pkg for widths and the status struct.
module ptcl_rem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ptcl_pkg::TIME_W-1:0]   i_dividend,
    input  logic [ptcl_pkg::STEP_W-1:0]   i_divisor,
    output ptcl_pkg::t_rem_stat           o_stat,
    output logic [ptcl_pkg::STEP_W-1:0]   o_rem
);

    localparam int ITER  = ptcl_pkg::TIME_W;
    localparam int CNT_W = $clog2(ITER);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [ptcl_pkg::TIME_W-1:0] r_dvd;
    logic [ptcl_pkg::STEP_W-1:0] r_div;
    logic [ptcl_pkg::STEP_W-1:0] r_rem;

    logic [ptcl_pkg::STEP_W:0]   shifted;
    logic [ptcl_pkg::STEP_W:0]   diff;
    logic [ptcl_pkg::STEP_W-1:0] n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        shifted = {r_rem, r_dvd[ptcl_pkg::TIME_W-1]};
        diff    = shifted - {1'b0, r_div};
        if (!diff[ptcl_pkg::STEP_W]) begin
            n_rem = diff[ptcl_pkg::STEP_W-1:0];
        end else begin
            n_rem = shifted[ptcl_pkg::STEP_W-1:0];
        end
    end

    // Iteration control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[ptcl_pkg::TIME_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

// ===== design/ptcl_apb.sv =====
// Configuration port: holds the realtime and monotonic start registers.
// Depends on ptcl_pkg for addresses and the write event struct.
module ptcl_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptcl_pkg::ADDR_W-1:0]   paddr,
    input  logic [ptcl_pkg::TIME_W-1:0]   pwdata,
    output logic [ptcl_pkg::TIME_W-1:0]   prdata,
    output logic                          pready,
    output ptcl_pkg::t_cfg_wr             o_cfg_wr,
    output logic [ptcl_pkg::TIME_W-1:0]   o_realtime_start,
    output logic [ptcl_pkg::TIME_W-1:0]   o_monotonic_start
);

    logic                        wr_en;
    logic [ptcl_pkg::TIME_W-1:0] r_realtime_start;
    logic [ptcl_pkg::TIME_W-1:0] r_monotonic_start;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Address decode of the write transaction.
    always_comb begin
        o_cfg_wr.wr_realtime  = 1'b0;
        o_cfg_wr.wr_monotonic = 1'b0;
        o_cfg_wr.value        = pwdata;
        if (wr_en) begin
            case (paddr)
                ptcl_pkg::ADDR_REALTIME_START:  o_cfg_wr.wr_realtime  = 1'b1;
                ptcl_pkg::ADDR_MONOTONIC_START: o_cfg_wr.wr_monotonic = 1'b1;
                default: ;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_realtime_start  <= '0;
            r_monotonic_start <= '0;
        end else begin
            if (o_cfg_wr.wr_realtime) begin
                r_realtime_start <= pwdata;
            end
            if (o_cfg_wr.wr_monotonic) begin
                r_monotonic_start <= pwdata;
            end
        end
    end

    // Read mux.
    always_comb begin
        case (paddr)
            ptcl_pkg::ADDR_REALTIME_START:  prdata = r_realtime_start;
            ptcl_pkg::ADDR_MONOTONIC_START: prdata = r_monotonic_start;
            default:                        prdata = '0;
        endcase
    end

    assign o_realtime_start  = r_realtime_start;
    assign o_monotonic_start = r_monotonic_start;

endmodule

// ===== design/periodic_timer_with_clock_latch_top.sv =====
// Top level of the periodic timer with clock latch.
// Depends on ptcl_pkg, ptcl_apb and ptcl_rem.

// Each input transaction is a tick, a clock read or a period write, and gives exactly one
// result transaction. The block works on one transaction at a time. A period write or an
// unused operation goes from the execute state to the output register; a clock read first
// latches the selected clock; a tick with the timer off goes straight on; an enabled tick
// passes the arm and check states, and a tick that fires also the compare state. A tick
// that fires while the timer is more than one period behind also waits for the bit-serial
// remainder unit, which finds the missed-period offset with 64 restoring steps. The result
// waits in the done state while the output register holds a stalled earlier result. A new
// input is accepted as soon as the previous one has been placed in the output register,
// even while that result is still stalled. The registers are realtime_start at byte
// address 0 and monotonic_start at byte address 8 (64-bit data); writing monotonic_start
// also loads the running nanosecond counter. Configure only while the block is idle.
module periodic_timer_with_clock_latch_top #(
    parameter int MIN_PERIOD_US = 1000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptcl_pkg::ADDR_W-1:0]   paddr,
    input  logic [ptcl_pkg::TIME_W-1:0]   pwdata,
    output logic [ptcl_pkg::TIME_W-1:0]   prdata,
    output logic                          pready,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_operation,
    input  logic [1:0]                    i_clock_select,
    input  logic [31:0]                   i_period_micros,
    input  logic [31:0]                   i_elapsed_ns,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_irq,
    output logic [31:0]                   o_time_low,
    output logic [31:0]                   o_time_high,
    output logic                          o_enabled_status
);

    localparam int TW = ptcl_pkg::TIME_W;
    localparam int SW = ptcl_pkg::STEP_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ARM,
        ST_CHECK,
        ST_CMP,
        ST_DIV,
        ST_SUB_REM,
        ST_ADD_STEP,
        ST_READ,
        ST_DONE
    } t_state;

    ptcl_pkg::t_cfg_wr   cfg_wr;
    ptcl_pkg::t_rem_stat rem_stat;
    logic [TW-1:0]       realtime_start;
    logic [TW-1:0]       monotonic_start;
    logic [SW-1:0]       rem;

    t_state              r_state;
    logic [1:0]          r_op;
    logic [1:0]          r_sel;
    logic [31:0]         r_per;
    logic [31:0]         r_el;
    logic [TW-1:0]       r_now;
    logic [TW-1:0]       r_dl;
    logic [31:0]         r_period;
    logic [SW-1:0]       r_step;
    logic                r_timer_on;
    logic [TW-1:0]       r_latched_real;
    logic [TW-1:0]       r_latched_mono;
    logic [TW-1:0]       r_latched_boot;
    logic [TW-1:0]       r_boot;
    logic                r_res_irq;
    logic [TW-1:0]       r_res_time;
    logic                r_rem_start;
    logic                r_out_valid;
    logic                r_out_irq;
    logic [TW-1:0]       r_out_time;
    logic                r_out_en;

    logic                in_accept;
    logic                out_free;
    logic [TW-1:0]       step64;
    logic [31:0]         per_clamped;

    ptcl_apb u_apb (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_cfg_wr          (cfg_wr),
        .o_realtime_start  (realtime_start),
        .o_monotonic_start (monotonic_start)
    );

    ptcl_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_rem_start),
        .i_dividend (r_now - r_dl),
        .i_divisor  (r_step),
        .o_stat     (rem_stat),
        .o_rem      (rem)
    );

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign step64      = {{(TW - SW){1'b0}}, r_step};
    assign per_clamped = (r_per < 32'(MIN_PERIOD_US)) ? 32'(MIN_PERIOD_US) : r_per;

    // Sequencer, timer state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_now          <= '0;
            r_dl           <= '0;
            r_period       <= '0;
            r_step         <= '0;
            r_timer_on     <= 1'b0;
            r_latched_real <= '0;
            r_latched_mono <= '0;
            r_latched_boot <= '0;
            r_rem_start    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_rem_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // Monotonic start write reloads the counter; user: idle only, not enforced.
            if (cfg_wr.wr_monotonic) begin
                r_now <= cfg_wr.value;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_op       <= i_operation;
                        r_sel      <= i_clock_select;
                        r_per      <= i_period_micros;
                        r_el       <= i_elapsed_ns;
                        r_res_irq  <= 1'b0;
                        r_res_time <= '0;
                        r_state    <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    case (r_op)
                        ptcl_pkg::OP_TICK: begin
                            r_now <= r_now + {{(TW - 32){1'b0}}, r_el};
                            if (!r_timer_on) begin
                                r_dl    <= '0;
                                r_state <= ST_DONE;
                            end else if (r_period == '0) begin
                                r_timer_on <= 1'b0;
                                r_dl       <= '0;
                                r_state    <= ST_DONE;
                            end else begin
                                r_state <= ST_ARM;
                            end
                        end
                        ptcl_pkg::OP_READ: begin
                            r_boot  <= r_now - monotonic_start;
                            r_state <= ST_READ;
                        end
                        ptcl_pkg::OP_PERIOD: begin
                            r_dl <= '0;
                            if (r_per == '0) begin
                                r_timer_on <= 1'b0;
                                r_period   <= '0;
                            end else begin
                                r_timer_on <= 1'b1;
                                r_period   <= per_clamped;
                                r_step     <= SW'({{(SW - 32){1'b0}}, per_clamped}
                                                  * SW'(ptcl_pkg::US_TO_NS));
                            end
                            r_state <= ST_DONE;
                        end
                        default: begin
                            r_state <= ST_DONE;
                        end
                    endcase
                end
                // Arm the deadline on the first enabled tick.
                ST_ARM: begin
                    if (r_dl == '0) begin
                        r_dl <= r_now + step64;
                    end
                    r_state <= ST_CHECK;
                end
                // Fire when the deadline has been reached, then move it one step on.
                ST_CHECK: begin
                    if (r_now < r_dl) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_dl      <= r_dl + step64;
                        r_res_irq <= 1'b1;
                        r_state   <= ST_CMP;
                    end
                end
                // Still behind: the new deadline is now - ((now - dl) mod step) + step.
                ST_CMP: begin
                    if (r_dl < r_now) begin
                        r_rem_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (rem_stat.done) begin
                        r_state <= ST_SUB_REM;
                    end
                end
                ST_SUB_REM: begin
                    r_dl    <= r_now - {{(TW - SW){1'b0}}, rem};
                    r_state <= ST_ADD_STEP;
                end
                ST_ADD_STEP: begin
                    r_dl    <= r_dl + step64;
                    r_state <= ST_DONE;
                end
                // Latch the selected clock.
                ST_READ: begin
                    case (r_sel)
                        ptcl_pkg::SEL_REAL: begin
                            r_latched_real <= realtime_start + r_boot;
                            r_res_time     <= realtime_start + r_boot;
                        end
                        ptcl_pkg::SEL_MONO: begin
                            r_latched_mono <= r_now;
                            r_res_time     <= r_now;
                        end
                        ptcl_pkg::SEL_BOOT: begin
                            r_latched_boot <= r_boot;
                            r_res_time     <= r_boot;
                        end
                        default: begin
                            r_res_time <= '0;
                        end
                    endcase
                    r_state <= ST_DONE;
                end
                // Hand the result to the output register once it is free.
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_irq   <= r_res_irq;
                        r_out_time  <= r_res_time;
                        r_out_en    <= r_timer_on;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_irq            = r_out_irq;
    assign o_time_low       = r_out_time[31:0];
    assign o_time_high      = r_out_time[TW-1:32];
    assign o_enabled_status = r_out_en;

`ifndef ASSERT_OFF
    // A fired timer is always reported as enabled.
    a_irq_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_irq |-> o_enabled_status)
        else $error("irq reported with timer disabled");

    // An enabled timer always holds a clamped period.
    a_period_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer_on |-> (r_period >= 32'(MIN_PERIOD_US)))
        else $error("enabled timer with period below minimum");

    // The remainder unit delivers a value below the step.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.done |-> (rem < r_step))
        else $error("remainder not below step");

    // The remainder unit only runs during catch-up.
    a_rem_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.busy |-> (r_state == ST_DIV))
        else $error("remainder unit busy outside catch-up");
`endif

endmodule
